// ===== design/sms_pkg.sv =====
`default_nettype none

package sms_pkg;

  // Command codes of an input item.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // Motion phases.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_TURN  = 2'd2;
  localparam logic [1:0] PH_STOP  = 2'd3;

  // Event codes of a result item.
  localparam logic [2:0] EV_NONE          = 3'd0;
  localparam logic [2:0] EV_START_SEEN    = 3'd1;
  localparam logic [2:0] EV_STOP_SEEN     = 3'd2;
  localparam logic [2:0] EV_START_TIMEOUT = 3'd3;
  localparam logic [2:0] EV_STOP_TIMEOUT  = 3'd4;
  localparam logic [2:0] EV_STOP_ISSUED   = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_GYRO_BIAS      = 2'd0;
  localparam logic [1:0] REG_START_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_STOP_TIMEOUT   = 2'd2;
  localparam logic [1:0] REG_SETTLE_SAMPLES = 2'd3;

  localparam logic [6:0] START_TIMEOUT_RST  = 7'd60;
  localparam logic [6:0] STOP_TIMEOUT_RST   = 7'd75;
  localparam logic [3:0] SETTLE_SAMPLES_RST = 4'd15;

  localparam int RATE_W = 26;
  localparam int ACC_W  = 48;
  localparam int PROD_W = 37;

  // Raw gyro to Q16 deg/s: 250 deg/s full scale over 32768 counts, times 65536.
  localparam logic signed [RATE_W-1:0] GYRO_SCALE = 26'sd500;
  localparam logic [31:0] DT_MAX = 32'd1023;

  // One degree is 131072000 accumulator units, that is 2^17 times 1000.
  localparam int DEG_SHIFT = 17;
  localparam logic [25:0] RND_HALF = 26'd65536000;
  localparam logic [31:0] SAT_POS_LIM = 32'd32768000;
  localparam logic [31:0] SAT_NEG_LIM = 32'd32769000;
  // ceil(2^35 / 1000); exact for every quotient input below 2^25.
  localparam logic [25:0] RECIP = 26'd34359739;
  localparam int RECIP_SHIFT = 35;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] gyro_raw;
    logic signed [31:0] encoder_count;
    logic [31:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         event_code;
    logic               stop_motor;
    logic               finished;
    logic signed [15:0] angle_deg;
    logic [1:0]         phase_now;
  } out_item_t;

  typedef struct packed {
    logic        en;
    logic [1:0]  index;
    logic [24:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic       load_item;
    logic       calc_rate;
    logic       calc_prod;
    logic       commit;
    logic       calc_round;
    logic       calc_div;
    logic       load_out;
    logic       clr;
    logic       tick_upd;
    logic       integ;
    logic [2:0] event_code;
    logic       stop_motor;
    logic       finished;
    logic [1:0] phase_now;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       enc_nz;
    logic       enc_same;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/sms_in_if.sv =====
`default_nettype none

interface sms_in_if import sms_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/sms_out_if.sv =====
`default_nettype none

interface sms_out_if import sms_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/sms_cfg_if.sv =====
`default_nettype none

interface sms_cfg_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [24:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/sms_ctrl.sv =====
`default_nettype none

module sms_ctrl import sms_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_wr_t   cfg_wr,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RATE  = 3'd1;
  localparam logic [2:0] S_PROD  = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_RND   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] seq, seq_next;
  logic [1:0] phase, phase_next;
  logic [6:0] tick, tick_next;
  logic [3:0] settle, settle_next;
  logic [6:0] start_to, stop_to;
  logic [3:0] settle_n;

  logic [2:0] ev, ev_next;
  logic       stopm, stopm_next;
  logic       fin, fin_next;
  logic       clr, clr_next;
  logic       tupd, tupd_next;
  logic       integ, integ_next;

  logic [6:0] tick_inc;
  logic [3:0] settle_inc;

  assign tick_inc   = tick + 7'd1;
  assign settle_inc = settle + 4'd1;

  // Motion phase decision for the item held in the datapath.
  always_comb begin
    phase_next  = phase;
    tick_next   = tick;
    settle_next = settle;
    ev_next     = EV_NONE;
    stopm_next  = 1'b0;
    fin_next    = 1'b0;
    clr_next    = 1'b0;
    tupd_next   = 1'b0;
    integ_next  = 1'b0;
    case (stat.cmd)
      CMD_START: begin
        clr_next    = 1'b1;
        phase_next  = PH_START;
        tick_next   = 7'd0;
        settle_next = 4'd0;
      end
      CMD_STOP: begin
        if (phase inside {PH_START, PH_TURN}) begin
          stopm_next = 1'b1;
          tick_next  = 7'd0;
          phase_next = PH_STOP;
        end
      end
      CMD_TICK: begin
        if (phase != PH_IDLE) begin
          tupd_next = 1'b1;
        end
        case (phase)
          PH_START: begin
            if (tick_inc == start_to) begin
              stopm_next = 1'b1;
              tick_next  = 7'd0;
              ev_next    = EV_START_TIMEOUT;
              fin_next   = 1'b1;
              phase_next = PH_IDLE;
            end else if (stat.enc_nz) begin
              phase_next = PH_TURN;
              ev_next    = EV_START_SEEN;
              tick_next  = 7'd0;
              integ_next = 1'b1;
            end else begin
              tick_next = tick_inc;
            end
          end
          PH_STOP: begin
            if (tick == 7'd0) begin
              ev_next = EV_STOP_ISSUED;
            end
            integ_next = 1'b1;
            tick_next  = tick_inc;
            if (tick_inc == 7'd1) begin
              settle_next = 4'd0;
            end else if (tick_inc == stop_to) begin
              stopm_next = 1'b1;
              tick_next  = 7'd0;
              ev_next    = EV_STOP_TIMEOUT;
              fin_next   = 1'b1;
              phase_next = PH_IDLE;
            end else if (stat.enc_same) begin
              settle_next = settle_inc;
              if (settle_inc == settle_n) begin
                ev_next    = EV_STOP_SEEN;
                fin_next   = 1'b1;
                phase_next = PH_IDLE;
              end
            end else begin
              settle_next = 4'd0;
            end
          end
          PH_TURN: begin
            integ_next = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    seq_next = seq;
    case (seq)
      S_IDLE:  if (in_valid) seq_next = S_RATE;
      S_RATE:  seq_next = S_PROD;
      S_PROD:  seq_next = S_ACC;
      S_ACC:   seq_next = S_RND;
      S_RND:   seq_next = S_DIV;
      S_DIV:   seq_next = S_EMIT;
      S_EMIT:  if (stat.out_free) seq_next = S_IDLE;
      default: seq_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq      <= S_IDLE;
      phase    <= PH_IDLE;
      tick     <= 7'd0;
      settle   <= 4'd0;
      start_to <= START_TIMEOUT_RST;
      stop_to  <= STOP_TIMEOUT_RST;
      settle_n <= SETTLE_SAMPLES_RST;
      ev       <= EV_NONE;
      stopm    <= 1'b0;
      fin      <= 1'b0;
      clr      <= 1'b0;
      tupd     <= 1'b0;
      integ    <= 1'b0;
    end else begin
      seq <= seq_next;
      if (seq == S_RATE) begin
        phase  <= phase_next;
        tick   <= tick_next;
        settle <= settle_next;
        ev     <= ev_next;
        stopm  <= stopm_next;
        fin    <= fin_next;
        clr    <= clr_next;
        tupd   <= tupd_next;
        integ  <= integ_next;
      end
      if (cfg_wr.en) begin
        case (cfg_wr.index)
          REG_START_TIMEOUT:  start_to <= cfg_wr.data[6:0];
          REG_STOP_TIMEOUT:   stop_to  <= cfg_wr.data[6:0];
          REG_SETTLE_SAMPLES: settle_n <= cfg_wr.data[3:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign in_ready = (seq == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load_item  = (seq == S_IDLE) && in_valid;
    cmd.calc_rate  = (seq == S_RATE);
    cmd.calc_prod  = (seq == S_PROD);
    cmd.commit     = (seq == S_ACC);
    cmd.calc_round = (seq == S_RND);
    cmd.calc_div   = (seq == S_DIV);
    cmd.load_out   = (seq == S_EMIT) && stat.out_free;
    cmd.clr        = clr;
    cmd.tick_upd   = tupd;
    cmd.integ      = integ;
    cmd.event_code = ev;
    cmd.stop_motor = stopm;
    cmd.finished   = fin;
    cmd.phase_now  = phase;
  end

endmodule

`default_nettype wire

// ===== design/sms_dp.sv =====
`default_nettype none

module sms_dp import sms_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_wr_t   cfg_wr,
  input  in_item_t  in_data,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_ready
);

  in_item_t item;
  logic signed [24:0] gyro_bias;

  logic signed [RATE_W-1:0] prev_rate;
  logic [31:0]              prev_time;
  logic                     time_valid;
  logic signed [31:0]       prev_encoder;
  logic signed [ACC_W-1:0]  acc;

  logic signed [RATE_W-1:0] rate_r;
  logic [9:0]               dt_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [24:0]              y_r;
  logic                     neg_r;
  logic                     sat_r;
  logic signed [15:0]       angle_r;

  // Rate and time step.
  logic signed [RATE_W-1:0] raw_scaled, rate_calc;
  logic [31:0]              tdiff;
  logic [9:0]               dt_calc;

  assign raw_scaled = RATE_W'(item.gyro_raw) * GYRO_SCALE;
  assign rate_calc  = raw_scaled - RATE_W'(gyro_bias);
  assign tdiff      = item.time_ms - prev_time;

  always_comb begin
    if (!time_valid) begin
      dt_calc = 10'd0;
    end else if (tdiff > DT_MAX) begin
      dt_calc = DT_MAX[9:0];
    end else begin
      dt_calc = tdiff[9:0];
    end
  end

  // Trapezoid term.
  logic signed [RATE_W:0]   rsum;
  logic signed [10:0]       dt_s;
  logic signed [PROD_W-1:0] prod_calc;

  assign rsum      = (RATE_W+1)'(prev_rate) + (RATE_W+1)'(rate_r);
  assign dt_s      = $signed({1'b0, dt_r});
  assign prod_calc = PROD_W'(rsum) * PROD_W'(dt_s);

  // Saturating accumulate.
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_new;

  assign acc_sum = (ACC_W+1)'(acc) + (ACC_W+1)'(prod_r);

  always_comb begin
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_new = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_new = acc_sum[ACC_W-1:0];
    end
  end

  // Rounding half away from zero: add half a degree to the magnitude, then
  // drop the power-of-two part of the divisor; the factor 1000 follows.
  logic [ACC_W-1:0] mag;
  logic [ACC_W:0]   mag_rnd;
  logic [31:0]      y_calc;
  logic             sat_calc;

  assign mag      = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign mag_rnd  = {1'b0, mag} + (ACC_W+1)'(RND_HALF);
  assign y_calc   = mag_rnd[DEG_SHIFT+31:DEG_SHIFT];
  assign sat_calc = acc[ACC_W-1] ? (y_calc >= SAT_NEG_LIM) : (y_calc >= SAT_POS_LIM);

  // Division by 1000 through the reciprocal.
  logic [50:0]        qprod;
  logic [15:0]        q;
  logic signed [15:0] angle_calc;

  assign qprod = 51'(y_r) * 51'(RECIP);
  assign q     = qprod[RECIP_SHIFT+15:RECIP_SHIFT];

  always_comb begin
    if (sat_r) begin
      angle_calc = neg_r ? 16'sh8000 : 16'sh7fff;
    end else if (neg_r) begin
      angle_calc = $signed(-q);
    end else begin
      angle_calc = $signed(q);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
    if (cmd.calc_rate) begin
      rate_r <= rate_calc;
      dt_r   <= dt_calc;
    end
    if (cmd.calc_prod) begin
      prod_r <= prod_calc;
    end
    if (cmd.calc_round) begin
      y_r   <= y_calc[24:0];
      neg_r <= acc[ACC_W-1];
      sat_r <= sat_calc;
    end
    if (cmd.calc_div) begin
      angle_r <= angle_calc;
    end
    if (cmd.load_out) begin
      out_data.event_code <= cmd.event_code;
      out_data.stop_motor <= cmd.stop_motor;
      out_data.finished   <= cmd.finished;
      out_data.angle_deg  <= angle_r;
      out_data.phase_now  <= cmd.phase_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_bias    <= '0;
      prev_rate    <= '0;
      prev_time    <= '0;
      time_valid   <= 1'b0;
      prev_encoder <= '0;
      acc          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr.en && cfg_wr.index == REG_GYRO_BIAS) begin
        gyro_bias <= $signed(cfg_wr.data);
      end
      if (cmd.commit) begin
        if (cmd.clr) begin
          prev_rate    <= '0;
          prev_time    <= '0;
          time_valid   <= 1'b0;
          prev_encoder <= '0;
          acc          <= '0;
        end else begin
          if (cmd.tick_upd) begin
            prev_time    <= item.time_ms;
            time_valid   <= 1'b1;
            prev_encoder <= item.encoder_count;
          end
          if (cmd.integ) begin
            acc       <= acc_new;
            prev_rate <= rate_r;
          end
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.cmd      = item.cmd;
  assign stat.enc_nz   = (item.encoder_count != 32'sd0);
  assign stat.enc_same = (item.encoder_count == prev_encoder);
  assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== design/spin_motion_supervisor.sv =====
// Spin motion supervisor.
// Input items arrive on the sample channel: a start, a stop request, a sensor
// tick or a no-operation, each with the gyro reading, encoder count and
// timestamp. Every input item gives exactly one result item on the result
// channel, carrying the event, the motor stop flag, the finished flag, the
// integrated angle in whole degrees and the phase after the item.
// Configuration registers are written over the cfg channel, which is always
// ready; write them only while no item is in flight.
// An item passes from acceptance through six steps of the controller sequence
// (rate multiply, trapezoid product, saturating accumulate, rounding,
// reciprocal multiply, output load) before its result is presented. A new
// item is accepted only when the sequence is back at idle after the output load.
// The result sits in an output register, so the next item is accepted while
// a result waits; a stalled receiver holds the sequence at its output step.
// Synchronous reset returns to idle with all motion state cleared and the
// registers at their defaults.
`default_nettype none

module spin_motion_supervisor import sms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sms_cfg_if.sink    cfg,
  sms_in_if.sink     sample,
  sms_out_if.source  result
);

  cfg_wr_t   cfg_wr;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg.ready    = 1'b1;
  assign cfg_wr.en    = cfg.valid;
  assign cfg_wr.index = cfg.index;
  assign cfg_wr.data  = cfg.data;

  sms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sms_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .in_data   (sample.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (result.valid),
    .out_data  (result.data),
    .out_ready (result.ready)
  );

endmodule

`default_nettype wire

// ===== dv/spin_motion_supervisor_tb.sv =====
`timescale 1ns / 100ps

module spin_motion_supervisor_tb;
  import sms_pkg::*;

  localparam longint ACC_HI   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO   = -ACC_HI - 1;
  localparam longint DEG_UNIT = 131072000;
  localparam longint RAW_GAIN = 500;
  localparam longint DT_CLAMP = 1023;
  localparam int     BATCH    = 230;

  logic clk = 1'b0;
  logic rst;

  sms_cfg_if cfg_bus ();
  sms_in_if  smp_bus ();
  sms_out_if res_bus ();

  spin_motion_supervisor uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .sample (smp_bus),
    .result (res_bus)
  );

  always #6 clk = ~clk;

  // Shadow copy of the configuration registers.
  longint     bias_q16    = 0;
  logic [6:0] start_limit = START_TIMEOUT_RST;
  logic [6:0] stop_limit  = STOP_TIMEOUT_RST;
  logic [3:0] settle_need = SETTLE_SAMPLES_RST;

  // Predicted motion state.
  logic [1:0]  mo_phase     = PH_IDLE;
  logic [6:0]  mo_ticks     = '0;
  logic [3:0]  mo_settle    = '0;
  longint      mo_prev_rate = 0;
  logic [31:0] mo_prev_time = '0;
  logic        mo_time_ok   = 1'b0;
  logic [31:0] mo_prev_enc  = '0;
  longint      mo_acc       = 0;

  in_item_t  pending_items[$];
  out_item_t due_results[$];
  out_item_t oldest_due;
  logic      hold_tx     = 1'b1;
  int        tx_idle_pct = 17;
  int        rx_idle_pct = 60;
  int        errors      = 0;

  function automatic void fold_rate(input longint rate, input longint dt);
    longint sum;
    sum = mo_acc + (mo_prev_rate + rate) * dt;
    if (sum > ACC_HI) begin
      sum = ACC_HI;
    end else if (sum < ACC_LO) begin
      sum = ACC_LO;
    end
    mo_acc       = sum;
    mo_prev_rate = rate;
  endfunction

  function automatic out_item_t spin_step(input in_item_t it);
    out_item_t   r;
    longint      rate;
    longint      dt;
    longint      deg;
    logic [31:0] gap;
    r.event_code = EV_NONE;
    r.stop_motor = 1'b0;
    r.finished   = 1'b0;
    case (it.cmd)
      CMD_START: begin
        mo_phase     = PH_START;
        mo_ticks     = '0;
        mo_settle    = '0;
        mo_prev_rate = 0;
        mo_prev_time = '0;
        mo_time_ok   = 1'b0;
        mo_prev_enc  = '0;
        mo_acc       = 0;
      end
      CMD_STOP: begin
        if (mo_phase == PH_START || mo_phase == PH_TURN) begin
          r.stop_motor = 1'b1;
          mo_ticks     = '0;
          mo_phase     = PH_STOP;
        end
      end
      CMD_TICK: begin
        if (mo_phase != PH_IDLE) begin
          rate = longint'(it.gyro_raw) * RAW_GAIN - bias_q16;
          gap  = it.time_ms - mo_prev_time;
          dt   = !mo_time_ok ? 0 : (gap > DT_CLAMP) ? DT_CLAMP : longint'(gap);
          mo_prev_time = it.time_ms;
          mo_time_ok   = 1'b1;
          case (mo_phase)
            PH_START: begin
              mo_ticks = mo_ticks + 7'd1;
              if (mo_ticks == start_limit) begin
                r.stop_motor = 1'b1;
                r.event_code = EV_START_TIMEOUT;
                r.finished   = 1'b1;
                mo_ticks     = '0;
                mo_phase     = PH_IDLE;
              end else if (it.encoder_count != 0) begin
                r.event_code = EV_START_SEEN;
                mo_phase     = PH_TURN;
                mo_ticks     = '0;
                fold_rate(rate, dt);
              end
            end
            PH_STOP: begin
              if (mo_ticks == 0) r.event_code = EV_STOP_ISSUED;
              mo_ticks = mo_ticks + 7'd1;
              fold_rate(rate, dt);
              if (mo_ticks == 7'd1) begin
                mo_settle = '0;
              end else if (mo_ticks == stop_limit) begin
                r.stop_motor = 1'b1;
                r.event_code = EV_STOP_TIMEOUT;
                r.finished   = 1'b1;
                mo_ticks     = '0;
                mo_phase     = PH_IDLE;
              end else if (mo_prev_enc == it.encoder_count) begin
                mo_settle = mo_settle + 4'd1;
                if (mo_settle == settle_need) begin
                  r.event_code = EV_STOP_SEEN;
                  r.finished   = 1'b1;
                  mo_phase     = PH_IDLE;
                end
              end else begin
                mo_settle = '0;
              end
            end
            default: fold_rate(rate, dt);
          endcase
          mo_prev_enc = it.encoder_count;
        end
      end
      default: ;
    endcase
    // Whole degrees, rounded half away from zero.
    if (mo_acc >= 0) begin
      deg = (mo_acc + DEG_UNIT / 2) / DEG_UNIT;
    end else begin
      deg = -((-mo_acc + DEG_UNIT / 2) / DEG_UNIT);
    end
    if (deg > 32767) deg = 32767;
    if (deg < -32768) deg = -32768;
    r.angle_deg = deg[15:0];
    r.phase_now = mo_phase;
    return r;
  endfunction

  // Sample channel: an item is predicted at the edge where it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      smp_bus.valid <= 1'b0;
    end else begin
      if (smp_bus.valid && smp_bus.ready) due_results.push_back(spin_step(smp_bus.data));
      if (!smp_bus.valid || smp_bus.ready) begin
        if (pending_items.size() != 0 && !hold_tx && $urandom_range(99) >= tx_idle_pct) begin
          smp_bus.data  <= pending_items.pop_front();
          smp_bus.valid <= 1'b1;
        end else begin
          smp_bus.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %h, got %h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result expected none, got %h", $time, res_bus.data);
          errors++;
        end else begin
          oldest_due = due_results.pop_front();
          check_field("event_code", oldest_due.event_code, res_bus.data.event_code);
          check_field("stop_motor", oldest_due.stop_motor, res_bus.data.stop_motor);
          check_field("finished", oldest_due.finished, res_bus.data.finished);
          check_field("angle_deg", oldest_due.angle_deg, res_bus.data.angle_deg);
          check_field("phase_now", oldest_due.phase_now, res_bus.data.phase_now);
        end
      end
      res_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [24:0] val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_GYRO_BIAS:      bias_q16 = longint'(signed'(val));
      REG_START_TIMEOUT:  start_limit = val[6:0];
      REG_STOP_TIMEOUT:   stop_limit = val[6:0];
      REG_SETTLE_SAMPLES: settle_need = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [24:0] bias, input logic [6:0] start_to,
                          input logic [6:0] stop_to, input logic [3:0] settle);
    write_reg(REG_GYRO_BIAS, bias);
    write_reg(REG_START_TIMEOUT, {18'd0, start_to});
    write_reg(REG_STOP_TIMEOUT, {18'd0, stop_to});
    write_reg(REG_SETTLE_SAMPLES, {21'd0, settle});
  endtask

  // Lets the queued items through, then holds the sender until every result is back.
  task automatic run_queued();
    int waited;
    hold_tx = 1'b0;
    while (pending_items.size() != 0) @(negedge clk);
    hold_tx = 1'b1;
    waited  = 0;
    while ((smp_bus.valid || due_results.size() != 0) && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    if (due_results.size() != 0) begin
      $display("%0t: %0d results missing, next expected %h, got nothing", $time,
               due_results.size(), due_results[0]);
      errors++;
      due_results.delete();
    end
    repeat (12) @(negedge clk);
  endtask

  task automatic queue_item(input logic [1:0] c, input logic [15:0] g,
                            input logic [31:0] e, input logic [31:0] t);
    in_item_t it;
    it.cmd           = c;
    it.gyro_raw      = g;
    it.encoder_count = e;
    it.time_ms       = t;
    pending_items.push_back(it);
  endtask

  function automatic logic [15:0] pick_gyro();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly the 10 ms cadence, with repeated stamps, long gaps and wild jumps mixed in.
  function automatic logic [31:0] next_gap();
    case ($urandom_range(39))
      0, 1:    return 32'd0;
      2, 3:    return $urandom_range(100000, 1024);
      4:       return $urandom;
      default: return $urandom_range(12, 8);
    endcase
  endfunction

  task automatic add_motion();
    logic [31:0] t;
    logic [31:0] enc;
    int          n;
    t = $urandom;
    queue_item(CMD_START, pick_gyro(), $urandom, t);
    // Now and then the encoder stays at zero until the start timeout fires.
    if ($urandom_range(9) == 0) begin
      n = (start_limit == 0) ? 128 : int'(start_limit);
    end else begin
      n = $urandom_range(3, 0);
    end
    repeat (n) begin
      t += next_gap();
      queue_item(CMD_TICK, pick_gyro(), 32'd0, t);
    end
    if ($urandom_range(19) == 0) queue_item(CMD_STOP, pick_gyro(), $urandom, t);
    enc = 32'd1;
    repeat ($urandom_range(12, 1)) begin
      t += next_gap();
      enc = $urandom;
      if (enc == 0) enc = 32'd1;
      queue_item(CMD_TICK, pick_gyro(), enc, t);
      if ($urandom_range(19) == 0) queue_item(CMD_NOP, pick_gyro(), $urandom, $urandom);
    end
    queue_item(CMD_STOP, pick_gyro(), $urandom, t);
    if ($urandom_range(9) == 0) queue_item(CMD_STOP, pick_gyro(), $urandom, t);
    if ($urandom_range(9) == 0) begin
      // The wheels never settle; with a limit below two this runs past the counter wrap.
      n = (stop_limit < 2) ? 140 : int'(stop_limit) + 1;
      repeat (n) begin
        t += next_gap();
        queue_item(CMD_TICK, pick_gyro(), $urandom, t);
      end
    end else begin
      repeat ($urandom_range(3, 0)) begin
        t += next_gap();
        enc = $urandom;
        queue_item(CMD_TICK, pick_gyro(), enc, t);
      end
      n = ((settle_need == 0) ? 16 : int'(settle_need)) + 2;
      repeat (n) begin
        t += next_gap();
        queue_item(CMD_TICK, pick_gyro(), enc, t);
      end
    end
  endtask

  task automatic add_batch();
    int goal;
    goal = pending_items.size() + BATCH;
    while (pending_items.size() < goal) begin
      if ($urandom_range(9) < 8) begin
        add_motion();
      end else begin
        repeat ($urandom_range(8, 1)) queue_item(2'($urandom), pick_gyro(), $urandom, $urandom);
      end
    end
  endtask

  // A spin long enough at full rate and clamped dt to drive the angle into saturation.
  task automatic add_long_turn(input logic [15:0] raw);
    logic [31:0] t;
    t = $urandom;
    queue_item(CMD_START, raw, 32'd0, t);
    repeat (80) begin
      t += 32'd5000;
      queue_item(CMD_TICK, raw, $urandom | 32'd1, t);
    end
    queue_item(CMD_STOP, raw, 32'd7, t);
    repeat (17) begin
      t += 32'd10;
      queue_item(CMD_TICK, raw, 32'd7, t);
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_GYRO_BIAS;
    cfg_bus.data  = '0;
    smp_bus.valid = 1'b0;
    smp_bus.data  = '0;
    res_bus.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    set_regs(25'd0, START_TIMEOUT_RST, STOP_TIMEOUT_RST, 4'd2);
    queue_item(CMD_NOP, 16'h8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(CMD_TICK, 16'h7FFF, 32'h8000_0000, 32'd0);
    queue_item(CMD_STOP, 16'h0000, 32'd0, 32'd0);
    queue_item(CMD_START, 16'h1234, 32'd0, 32'hFFFF_FFF0);
    queue_item(CMD_TICK, 16'h7FFF, 32'd0, 32'hFFFF_FFF0);
    queue_item(CMD_STOP, 16'h7FFF, 32'd0, 32'hFFFF_FFF6);
    queue_item(CMD_TICK, 16'h7FFF, 32'd0, 32'hFFFF_FFFA);
    queue_item(CMD_START, 16'h0000, 32'd5, 32'hFFFF_FFFA);
    queue_item(CMD_TICK, 16'h8000, 32'd0, 32'hFFFF_FFFA);
    // The timestamp wraps here, and the encoder first moves.
    queue_item(CMD_TICK, 16'h8000, 32'h8000_0000, 32'h0000_0004);
    queue_item(CMD_TICK, 16'h7FFF, 32'h7FFF_FFFF, 32'h0000_138C);
    queue_item(CMD_TICK, 16'h0000, 32'hFFFF_FFFF, 32'h0000_138C);
    queue_item(CMD_NOP, 16'h7FFF, 32'd0, 32'd0);
    queue_item(CMD_TICK, 16'h8000, 32'h0000_0001, 32'h0000_0000);
    queue_item(CMD_STOP, 16'h0000, 32'd0, 32'd0);
    queue_item(CMD_STOP, 16'h0000, 32'd0, 32'd0);
    queue_item(CMD_TICK, 16'h7FFF, 32'h0000_ABCD, 32'h0000_0010);
    queue_item(CMD_TICK, 16'h8000, 32'h0000_ABCD, 32'h0000_001A);
    queue_item(CMD_TICK, 16'h7FFF, 32'h0000_ABCD, 32'h0000_0024);
    queue_item(CMD_TICK, 16'h7FFF, 32'h0000_ABCD, 32'h0000_002E);
    run_queued();

    set_regs(25'd0, START_TIMEOUT_RST, STOP_TIMEOUT_RST, SETTLE_SAMPLES_RST);
    add_batch();
    run_queued();
    set_regs(25'h0FF_FFFF, 7'd127, 7'd127, 4'd15);
    add_batch();
    run_queued();

    tx_idle_pct = 60;
    rx_idle_pct = 17;
    set_regs(25'h100_0000, 7'd1, 7'd2, 4'd1);
    add_batch();
    run_queued();
    set_regs(25'($urandom), 7'd0, 7'd0, 4'd0);
    add_batch();
    run_queued();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_regs(25'($urandom), 7'd5, 7'd1, 4'd3);
    add_batch();
    run_queued();
    set_regs(25'($urandom_range(200000)), 7'($urandom_range(20, 2)),
             7'($urandom_range(30, 3)), 4'($urandom_range(6, 1)));
    add_batch();
    run_queued();

    set_regs(25'h100_0000, 7'd127, 7'd127, 4'd15);
    add_long_turn(16'h7FFF);
    run_queued();
    set_regs(25'h0FF_FFFF, 7'd127, 7'd127, 4'd15);
    add_long_turn(16'h8000);
    run_queued();

    if (errors == 0) begin
      $display("** spin_motion_supervisor: PASSED **");
    end else begin
      $display("** spin_motion_supervisor: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("** spin_motion_supervisor: FAILED **");
    $finish;
  end

endmodule
